### rtl/hwf_pkg.sv
// ----------------------------------------------------------------------------
// hwf_pkg
// shared types, constants and helpers for the haar wavelet fusion block
// ----------------------------------------------------------------------------
package hwf_pkg;

  // number of byte lanes that go through the fusion, the rest are copied
  localparam int COLOR_CHANNELS = 3;
  localparam int FUSED_LANES    = (COLOR_CHANNELS > 4) ? 4 : COLOR_CHANNELS;

  localparam int PIX_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int LANES   = PIX_W / BYTE_W;
  localparam int COEF_W  = 16;
  localparam int BYTE_MAX = (1 << BYTE_W) - 1;

  typedef logic [PIX_W-1:0]         pixel_t;
  // 2x2 block, index 0 top left, 1 top right, 2 bottom left, 3 bottom right
  typedef pixel_t [3:0]             block_t;
  typedef logic [3:0][BYTE_W-1:0]   quad_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    coef_t ll;
    coef_t hl;
    coef_t lh;
    coef_t hh;
  } coefs_t;

  // floor(x/2)
  function automatic coef_t half_floor(input coef_t x);
    return x >>> 1;
  endfunction

  function automatic coef_t magnitude(input coef_t x);
    return (x < 0) ? -x : x;
  endfunction

  // larger magnitude wins, first operand on a tie
  function automatic coef_t pick_larger(input coef_t a, input coef_t b);
    return (magnitude(a) >= magnitude(b)) ? a : b;
  endfunction

  function automatic logic [BYTE_W-1:0] clamp_byte(input coef_t v);
    if (v < 0) begin
      return '0;
    end else if (v > coef_t'(BYTE_MAX)) begin
      return BYTE_W'(BYTE_MAX);
    end else begin
      return v[BYTE_W-1:0];
    end
  endfunction

  function automatic coef_t widen(input logic [BYTE_W-1:0] b);
    return coef_t'({{(COEF_W-BYTE_W){1'b0}}, b});
  endfunction

endpackage

### rtl/hwf_in_if.sv
// ----------------------------------------------------------------------------
// hwf_in_if
// request channel carrying one 2x2 block from each source image
// ----------------------------------------------------------------------------
interface hwf_in_if;
  logic            valid;
  logic            ready;
  hwf_pkg::pixel_t first_top_left;
  hwf_pkg::pixel_t first_top_right;
  hwf_pkg::pixel_t first_bottom_left;
  hwf_pkg::pixel_t first_bottom_right;
  hwf_pkg::pixel_t second_top_left;
  hwf_pkg::pixel_t second_top_right;
  hwf_pkg::pixel_t second_bottom_left;
  hwf_pkg::pixel_t second_bottom_right;
  logic            edge_passthrough;

  modport source (
    output valid, first_top_left, first_top_right, first_bottom_left,
           first_bottom_right, second_top_left, second_top_right,
           second_bottom_left, second_bottom_right, edge_passthrough,
    input  ready
  );

  modport sink (
    input  valid, first_top_left, first_top_right, first_bottom_left,
           first_bottom_right, second_top_left, second_top_right,
           second_bottom_left, second_bottom_right, edge_passthrough,
    output ready
  );
endinterface

### rtl/hwf_out_if.sv
// ----------------------------------------------------------------------------
// hwf_out_if
// result channel carrying one fused 2x2 block
// ----------------------------------------------------------------------------
interface hwf_out_if;
  logic            valid;
  logic            ready;
  hwf_pkg::pixel_t fused_top_left;
  hwf_pkg::pixel_t fused_top_right;
  hwf_pkg::pixel_t fused_bottom_left;
  hwf_pkg::pixel_t fused_bottom_right;

  modport source (
    output valid, fused_top_left, fused_top_right, fused_bottom_left,
           fused_bottom_right,
    input  ready
  );

  modport sink (
    input  valid, fused_top_left, fused_top_right, fused_bottom_left,
           fused_bottom_right,
    output ready
  );
endinterface

### rtl/hwf_fwd.sv
// ----------------------------------------------------------------------------
// hwf_fwd
// forward 2x2 haar lifting of one byte lane, rows then columns
// ----------------------------------------------------------------------------
module hwf_fwd (
  input  hwf_pkg::quad_t  pix,
  output hwf_pkg::coefs_t coefs
);

  hwf_pkg::coef_t h0, l0, h1, l1, dl, dh;

  always_comb begin
    // row lifting
    h0 = hwf_pkg::widen(pix[1]) - hwf_pkg::widen(pix[0]);
    l0 = hwf_pkg::widen(pix[0]) + hwf_pkg::half_floor(h0);
    h1 = hwf_pkg::widen(pix[3]) - hwf_pkg::widen(pix[2]);
    l1 = hwf_pkg::widen(pix[2]) + hwf_pkg::half_floor(h1);
    // column lifting
    dl = l1 - l0;
    dh = h1 - h0;
    coefs.ll = l0 + hwf_pkg::half_floor(dl);
    coefs.lh = dl;
    coefs.hl = h0 + hwf_pkg::half_floor(dh);
    coefs.hh = dh;
  end

endmodule

### rtl/hwf_inv.sv
// ----------------------------------------------------------------------------
// hwf_inv
// inverse 2x2 haar lifting, columns then rows, with clamp to a byte
// ----------------------------------------------------------------------------
module hwf_inv (
  input  hwf_pkg::coefs_t coefs,
  output hwf_pkg::quad_t  pix
);

  hwf_pkg::coef_t l0, l1, h0, h1, p0, p1, p2, p3;

  always_comb begin
    // column inverse
    l0 = coefs.ll - hwf_pkg::half_floor(coefs.lh);
    l1 = coefs.lh + l0;
    h0 = coefs.hl - hwf_pkg::half_floor(coefs.hh);
    h1 = coefs.hh + h0;
    // row inverse
    p0 = l0 - hwf_pkg::half_floor(h0);
    p1 = h0 + p0;
    p2 = l1 - hwf_pkg::half_floor(h1);
    p3 = h1 + p2;
    pix[0] = hwf_pkg::clamp_byte(p0);
    pix[1] = hwf_pkg::clamp_byte(p1);
    pix[2] = hwf_pkg::clamp_byte(p2);
    pix[3] = hwf_pkg::clamp_byte(p3);
  end

endmodule

### rtl/hwf_lane.sv
// ----------------------------------------------------------------------------
// hwf_lane
// fusion of one colour lane: two forward transforms, coefficient pick, inverse
// ----------------------------------------------------------------------------
module hwf_lane (
  input  hwf_pkg::quad_t first_pix,
  input  hwf_pkg::quad_t second_pix,
  output hwf_pkg::quad_t fused_pix
);

  hwf_pkg::coefs_t first_c, second_c, fused_c;

  hwf_fwd u_fwd_first (
    .pix   (first_pix),
    .coefs (first_c)
  );

  hwf_fwd u_fwd_second (
    .pix   (second_pix),
    .coefs (second_c)
  );

  // ll and hh from the second image, mixed bands by larger magnitude
  always_comb begin
    fused_c.ll = second_c.ll;
    fused_c.hh = second_c.hh;
    fused_c.hl = hwf_pkg::pick_larger(first_c.hl, second_c.hl);
    fused_c.lh = hwf_pkg::pick_larger(first_c.lh, second_c.lh);
  end

  hwf_inv u_inv (
    .coefs (fused_c),
    .pix   (fused_pix)
  );

endmodule

### rtl/haar_wavelet_image_fusion.sv
// ----------------------------------------------------------------------------
// haar_wavelet_image_fusion
// fuses two images one aligned 2x2 rgba block at a time via haar lifting
// ----------------------------------------------------------------------------
// stages: two register stages, the input register takes each accepted request
//   and the result register takes its fused block when it can advance
// throughput: one block per cycle while results are taken, set by the single pass
//   of lane logic between the input register and the result register
// reset: rst clears both valid flags, payload registers are not reset
// ----------------------------------------------------------------------------
module haar_wavelet_image_fusion (
  input  logic      clk,
  input  logic      rst,
  hwf_in_if.sink    pix_in,
  hwf_out_if.source pix_out
);

  // input register stage
  logic            s1_valid;
  hwf_pkg::block_t s1_first;
  hwf_pkg::block_t s1_second;
  logic            s1_pass;

  // result register stage
  logic            o_valid;
  hwf_pkg::block_t o_blk;

  // combinational fused block from the input register
  hwf_pkg::block_t fused;

  // per lane output of the lane logic, gathered into the fused block below
  hwf_pkg::quad_t  lane_out [hwf_pkg::LANES];

  logic advance;
  logic in_take;

  // result register frees up when empty or being taken this cycle
  assign advance      = !o_valid || pix_out.ready;
  // input register can load when empty or while its content moves on
  assign pix_in.ready = !s1_valid || advance;
  assign in_take      = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (pix_in.ready) begin
        s1_valid <= pix_in.valid;
      end
      if (advance) begin
        o_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_first[0]  <= pix_in.first_top_left;
      s1_first[1]  <= pix_in.first_top_right;
      s1_first[2]  <= pix_in.first_bottom_left;
      s1_first[3]  <= pix_in.first_bottom_right;
      s1_second[0] <= pix_in.second_top_left;
      s1_second[1] <= pix_in.second_top_right;
      s1_second[2] <= pix_in.second_bottom_left;
      s1_second[3] <= pix_in.second_bottom_right;
      s1_pass      <= pix_in.edge_passthrough;
    end
    if (advance && s1_valid) begin
      o_blk <= fused;
    end
  end

  // per byte lane: fused colour lanes, copied lanes beyond the colour count
  for (genvar ch = 0; ch < hwf_pkg::LANES; ch++) begin : g_lane
    if (ch < hwf_pkg::FUSED_LANES) begin : g_fuse
      hwf_pkg::quad_t first_q, second_q, fused_q;

      always_comb begin
        for (int k = 0; k < 4; k++) begin
          first_q[k]  = s1_first[k][ch*hwf_pkg::BYTE_W +: hwf_pkg::BYTE_W];
          second_q[k] = s1_second[k][ch*hwf_pkg::BYTE_W +: hwf_pkg::BYTE_W];
        end
      end

      hwf_lane u_lane (
        .first_pix  (first_q),
        .second_pix (second_q),
        .fused_pix  (fused_q)
      );

      // passthrough returns the first image's bytes unchanged
      always_comb begin
        for (int k = 0; k < 4; k++) begin
          lane_out[ch][k] = s1_pass ? first_q[k] : fused_q[k];
        end
      end
    end else begin : g_copy
      // alpha and any other unfused lane come from the first image
      always_comb begin
        for (int k = 0; k < 4; k++) begin
          lane_out[ch][k] = s1_first[k][ch*hwf_pkg::BYTE_W +: hwf_pkg::BYTE_W];
        end
      end
    end
  end

  // gather the lanes back into rgba pixels
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int ch = 0; ch < hwf_pkg::LANES; ch++) begin
        fused[k][ch*hwf_pkg::BYTE_W +: hwf_pkg::BYTE_W] = lane_out[ch][k];
      end
    end
  end

  assign pix_out.valid              = o_valid;
  assign pix_out.fused_top_left     = o_blk[0];
  assign pix_out.fused_top_right    = o_blk[1];
  assign pix_out.fused_bottom_left  = o_blk[2];
  assign pix_out.fused_bottom_right = o_blk[3];

endmodule
